[hw/rtl/deq_pkg.sv]
// ---------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes plus the transaction payload types shared by the
// queue design.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EMIT
    } fsm_t;

    typedef struct packed {
        op_t                        operation;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_res;
        status_t                    status;
        logic                       last;
    } res_t;

endpackage

[hw/rtl/double_ended_queue.sv]
// ---------------------------------------------------------------------------
// Double-ended queue
// A push writes the memory when accepted, then queues its result. A pop or
// list step reads the memory into a data register and then the result
// register. No command is taken until the last result is queued. A list of
// N entries gives N results, one read per cycle while results are taken.
// Reset empties the queue at once; the ring memory needs no clearing pass.
// ---------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW+1)'(DEPTH))
        begin
            s = s - (PW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    logic [VALUE_W-1:0] ring_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    fsm_t               state_reg, state_next;
    logic [PW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [PW-1:0]      off_reg, off_next;
    status_t            pend_status_reg, pend_status_next;
    logic               pend_mem_reg, pend_mem_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic               rd_en;
    logic [PW-1:0]      rd_addr;
    logic               is_full;
    logic               is_empty;
    logic               out_free;

    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            off_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            off_reg       <= off_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_mem_reg    <= pend_mem_next;
        res_reg         <= res_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        rem_next         = rem_reg;
        off_next         = off_reg;
        pend_status_next = pend_status_reg;
        pend_mem_next    = pend_mem_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;
        wr_en            = 1'b0;
        wr_addr          = ring_add(front_reg, PW'(count_reg));
        rd_en            = 1'b0;
        rd_addr          = front_reg;
        cmd_ready        = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    rem_next      = CW'(1);
                    off_next      = PW'(1);
                    pend_mem_next = 1'b0;
                    case (cmd.operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            state_next = FSM_EMIT;
                            if (is_full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                pend_status_next = ST_OK;
                                wr_en            = 1'b1;
                                count_next       = count_reg + CW'(1);
                                if (cmd.operation == OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? PW'(DEPTH - 1)
                                                                   : front_reg - PW'(1);
                                    wr_addr    = front_next;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            state_next = FSM_EMIT;
                            if (is_empty)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pend_status_next = ST_OK;
                                pend_mem_next    = 1'b1;
                                rd_en            = 1'b1;
                                count_next       = count_reg - CW'(1);
                                if (cmd.operation == OP_POP_FRONT)
                                begin
                                    front_next = ring_add(front_reg, PW'(1));
                                end
                                else
                                begin
                                    rd_addr = ring_add(front_reg, PW'(count_reg - CW'(1)));
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            state_next = FSM_EMIT;
                            if (is_empty)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pend_status_next = ST_OK;
                                pend_mem_next    = 1'b1;
                                rd_en            = 1'b1;
                                rem_next         = count_reg;
                            end
                        end
                        default:
                        begin
                            state_next = FSM_IDLE;
                        end
                    endcase
                end
            end
            FSM_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.value_res  = pend_mem_reg ? rd_data_reg : '0;
                    res_next.status     = pend_status_reg;
                    res_next.last       = (rem_reg == CW'(1));
                    if (rem_reg == CW'(1))
                    begin
                        state_next = FSM_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ring_add(front_reg, off_reg);
                        off_next = off_reg + PW'(1);
                        rem_next = rem_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule
